>>> rtl/ctu_pkg.sv
package ctu_pkg;

  // Run length width, the sum width that follows from it, and the other field widths
  localparam int unsigned LEN_BITS  = 28;
  localparam int unsigned SUM_BITS  = LEN_BITS + 4;
  localparam int unsigned CODE_BITS = 4;
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned STAT_BITS = 3;

  typedef enum logic [STAT_BITS-1:0] {
    ST_OK       = 3'd0,
    ST_OVERFLOW = 3'd1,
    ST_NO_LEN   = 3'd2,
    ST_BAD_OP   = 3'd3,
    ST_TRAIL    = 3'd4
  } status_e;

  typedef enum logic [CODE_BITS-1:0] {
    OP_M   = 4'd0,
    OP_I   = 4'd1,
    OP_D   = 4'd2,
    OP_N   = 4'd3,
    OP_S   = 4'd4,
    OP_H   = 4'd5,
    OP_P   = 4'd6,
    OP_EQ  = 4'd7,
    OP_X   = 4'd8
  } op_e;

  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Character class handed from the decoder to the parser
  typedef struct packed {
    logic       is_space;
    logic       is_digit;
    logic [3:0] digit;
    logic       is_op;
    op_e        op_code;
    logic       is_star;
  } char_class_t;

endpackage

>>> rtl/ctu_in_if.sv
interface ctu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_text;

  modport source (output valid, output char_byte, output end_of_text, input ready);
  modport sink   (input valid, input char_byte, input end_of_text, output ready);
endinterface

>>> rtl/ctu_out_if.sv
interface ctu_out_if;
  logic        valid;
  logic        ready;
  logic        has_unit;
  logic [31:0] unit_word;
  logic [2:0]  status;
  logic        string_done;

  modport source (output valid, output has_unit, output unit_word, output status,
                  output string_done, input ready);
  modport sink   (input valid, input has_unit, input unit_word, input status,
                  input string_done, output ready);
endinterface

>>> rtl/ctu_char_class.sv
module ctu_char_class
  import ctu_pkg::*;
(
  input  logic [7:0]  char_i,
  output char_class_t class_o
);

  always_comb begin
    class_o          = '0;
    class_o.op_code  = OP_M;
    class_o.is_space = ((char_i >= CH_TAB) && (char_i <= CH_CR)) || (char_i == CH_SPACE);
    class_o.is_digit = (char_i >= CH_ZERO) && (char_i <= CH_NINE);
    class_o.digit    = 4'(char_i - CH_ZERO);
    class_o.is_star  = (char_i == CH_STAR);
    class_o.is_op    = 1'b1;
    case (char_i)
      CH_M:    class_o.op_code = OP_M;
      CH_I:    class_o.op_code = OP_I;
      CH_D:    class_o.op_code = OP_D;
      CH_N:    class_o.op_code = OP_N;
      CH_S:    class_o.op_code = OP_S;
      CH_H:    class_o.op_code = OP_H;
      CH_P:    class_o.op_code = OP_P;
      CH_EQ:   class_o.op_code = OP_EQ;
      CH_X:    class_o.op_code = OP_X;
      default: class_o.is_op   = 1'b0;
    endcase
  end

endmodule

>>> rtl/cigar_text_to_units.sv
// Channel | Dir | Beat payload
// in_i    | in  | char_byte[7:0], end_of_text
// out_o   | out | has_unit, unit_word[31:0], status[2:0], string_done
//
// One character per cycle while in_i.ready is high; a result appears on out_o in the cycle after its beat.
// The run length update (times ten plus digit, range check) sits between the
// parse state registers and the result register.
// in_i.ready is low only while a result is held and out_o.ready is low.
// Reset arms the parser for the first character of a new string.
module cigar_text_to_units
  import ctu_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  ctu_in_if.sink    in_i,
  ctu_out_if.source out_o
);

  char_class_t         cls;
  logic [LEN_BITS-1:0] acc_q, acc_d;
  logic                num_q, num_d;
  logic                err_q, err_d;
  logic                first_q;
  logic                out_valid_q;
  logic                has_q;
  logic [WORD_BITS-1:0] word_q;
  status_e             status_q;
  logic                done_q;

  logic                in_fire;
  logic                last;
  logic                lone_star;
  logic [SUM_BITS-1:0] sum;
  logic                ovf;
  logic                has;
  status_e             status;
  logic                emit;
  logic [WORD_BITS-1:0] word;

  ctu_char_class u_class (
    .char_i  (in_i.char_byte),
    .class_o (cls)
  );

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;
  assign last       = in_i.end_of_text;
  assign lone_star  = first_q && last && cls.is_star;

  // acc * 10 + digit as two shifted adds
  assign sum = (SUM_BITS'(acc_q) << 3) + (SUM_BITS'(acc_q) << 1) + SUM_BITS'(cls.digit);
  assign ovf = |sum[SUM_BITS-1:LEN_BITS];
  assign word = (WORD_BITS'(acc_q) << CODE_BITS) | WORD_BITS'(cls.op_code);

  always_comb begin
    has    = 1'b0;
    status = ST_OK;
    acc_d  = acc_q;
    num_d  = num_q;
    err_d  = err_q;
    emit   = 1'b0;
    if (err_q) begin
      if (last) begin
        err_d = 1'b0;
        acc_d = '0;
        num_d = 1'b0;
      end
    end else begin
      if (lone_star || cls.is_space) begin
        // nothing to do
      end else if (cls.is_digit) begin
        if (ovf) begin
          status = ST_OVERFLOW;
        end else begin
          acc_d = sum[LEN_BITS-1:0];
          num_d = 1'b1;
        end
      end else if (!num_q || (acc_q == '0)) begin
        status = ST_NO_LEN;
      end else if (!cls.is_op) begin
        status = ST_BAD_OP;
      end else begin
        has   = 1'b1;
        acc_d = '0;
        num_d = 1'b0;
      end
      if ((status == ST_OK) && last && num_d) begin
        status = ST_TRAIL;
      end
      if ((status != ST_OK) || last) begin
        acc_d = '0;
        num_d = 1'b0;
      end
      err_d = (status != ST_OK) && !last;
      emit  = (status != ST_OK) || last || has;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      num_q   <= 1'b0;
      err_q   <= 1'b0;
      first_q <= 1'b1;
    end else if (in_fire) begin
      acc_q   <= acc_d;
      num_q   <= num_d;
      err_q   <= err_d;
      first_q <= last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      has_q    <= has;
      word_q   <= has ? word : '0;
      status_q <= status;
      done_q   <= (status != ST_OK) || last;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.has_unit    = has_q;
  assign out_o.unit_word   = word_q;
  assign out_o.status      = status_q;
  assign out_o.string_done = done_q;

  // A unit is never reported together with an error
  a_unit_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && has_q) |-> (status_q == ST_OK))
    else $error("unit reported with error status");

  a_err_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q != ST_OK)) |-> (done_q && (word_q == '0)))
    else $error("error result not final or carries a word");

  a_latched_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && err_q) |-> !emit)
    else $error("result produced while error latched");

  a_acc_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !num_q |-> (acc_q == '0))
    else $error("run length pending without digits");

  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> (out_valid_q && $stable(word_q) && $stable(status_q)))
    else $error("stalled result changed");

endmodule
